>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> rtl/msfl_pkg.sv
// Types and codes for the shared free-list stack block.
`default_nettype none
package msfl_pkg;

	localparam int SID_W  = 2;
	localparam int DATA_W = 32;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                     mode;
		logic [SID_W-1:0]         stack_id;
		logic signed [DATA_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pop_value;
		logic [1:0]               status;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LINK,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> rtl/multi_stack_shared_free_list.sv
// Top level: several LIFO stacks threaded through one shared slot store with a free list.
// Each word passes in order: top read at accept (IDLE), link/data read (LINK), write-back
// (UPD) and result load (DONE); errors skip write-back. A new word is accepted only after
// the result of the last one is loaded; a held result stalls the result load.
// Reset (arst_n low, async): all stacks empty, free list = slot 0..CAPACITY-1 in order,
// no clearing pass; slots never handed out read their link as index+1 via a fill count.
`default_nettype none
`include "assert_macros.svh"
module multi_stack_shared_free_list import msfl_pkg::*; #(
	parameter int NUM_STACKS = 4,
	parameter int CAPACITY   = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int SLOT_W    = $clog2(CAPACITY);
	localparam int LINK_W    = $clog2(CAPACITY + 1);
	localparam int STACK_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int SID_EXT_W = (STACK_W > SID_W) ? STACK_W + 1 : SID_W + 1;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CAPACITY);

	// storage
	logic [LINK_W-1:0] top_mem  [NUM_STACKS];
	logic [LINK_W-1:0] link_mem [CAPACITY];
	logic [DATA_W-1:0] data_mem [CAPACITY];
	logic [NUM_STACKS-1:0] top_vld_q;     // stack has been written at least once

	// control state
	state_t state_q, state_d;
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] fresh_q;           // slots at or above this were never handed out

	// latched command
	logic              mode_q;
	logic [STACK_W-1:0] sid_q;
	logic              sid_ok_q;
	logic [DATA_W-1:0] value_q;

	// memory read results
	logic              top_hit_q;
	logic [LINK_W-1:0] top_rd_q;
	logic [SLOT_W-1:0] sel_slot_q;
	logic              fresh_hit_q;
	logic [LINK_W-1:0] link_rd_q;
	logic [DATA_W-1:0] data_rd_q;

	logic              rsp_valid_q;
	rsp_t              res_q, rsp_q;

	// comb
	logic               cmd_fire;
	logic [SID_EXT_W-1:0] sid_ext;
	logic [LINK_W-1:0]  top_eff;
	logic [LINK_W-1:0]  link_eff;
	logic [LINK_W-1:0]  sel_slot;
	logic [LINK_W-1:0]  chk_op;
	logic               chk_is_slot;
	logic [LINK_W-1:0]  next_link;
	logic               op_ok;
	logic               rsp_load;
	logic               upd_push, upd_pop;

	assign sid_ext  = SID_EXT_W'(cmd.stack_id);
	assign cmd_fire = cmd_valid && cmd_ready;

	assign top_eff  = top_hit_q ? top_rd_q : LINK_NULL;
	// a never-used slot still carries its reset link (index+1, last one null)
	assign link_eff = fresh_hit_q ? (LINK_W'(sel_slot_q) + LINK_W'(1)) : link_rd_q;
	assign sel_slot = (mode_q == MODE_PUSH) ? free_head_q : top_eff;

	// the one shared null check: slot candidate in LINK, fetched link in UPD
	assign chk_is_slot = chk_op < LINK_NULL;
	assign next_link   = chk_is_slot ? link_eff : LINK_NULL;
	assign op_ok       = sid_ok_q && chk_is_slot;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) state_d = ST_LINK;
			end
			ST_LINK: begin
				state_d = op_ok ? ST_UPD : ST_DONE;
			end
			ST_UPD: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_ready = 1'b0;
		chk_op    = sel_slot;
		rsp_load  = 1'b0;
		upd_push  = 1'b0;
		upd_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			ST_LINK: begin
				chk_op = sel_slot;
			end
			ST_UPD: begin
				chk_op   = link_eff;
				upd_push = (mode_q == MODE_PUSH);
				upd_pop  = (mode_q == MODE_POP);
			end
			ST_DONE: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= '0;
			fresh_q     <= '0;
			top_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_push) begin
				free_head_q     <= next_link;
				top_vld_q[sid_q] <= 1'b1;
				if (fresh_hit_q) fresh_q <= fresh_q + LINK_W'(1);
			end
			if (upd_pop) free_head_q <= LINK_W'(sel_slot_q);
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// command latch and stack-top read
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			mode_q    <= cmd.mode;
			sid_q     <= sid_ext[STACK_W-1:0];
			sid_ok_q  <= sid_ext < SID_EXT_W'(NUM_STACKS);
			value_q   <= cmd.push_value;
			top_rd_q  <= top_mem[sid_ext[STACK_W-1:0]];
			top_hit_q <= (sid_ext < SID_EXT_W'(NUM_STACKS)) && top_vld_q[sid_ext[STACK_W-1:0]];
		end
	end

	// link/data read of the chosen slot, result formation
	always_ff @(posedge clk) begin
		if (state_q == ST_LINK) begin
			sel_slot_q  <= sel_slot[SLOT_W-1:0];
			fresh_hit_q <= sel_slot >= fresh_q;
			link_rd_q   <= link_mem[sel_slot[SLOT_W-1:0]];
			data_rd_q   <= data_mem[sel_slot[SLOT_W-1:0]];
			res_q.pop_value <= '0;
			res_q.status    <= (mode_q == MODE_PUSH) ? STAT_OVERFLOW : STAT_UNDERFLOW;
		end
		if (state_q == ST_UPD) begin
			res_q.status    <= STAT_OK;
			res_q.pop_value <= upd_pop ? data_rd_q : '0;
		end
		if (rsp_load) rsp_q <= res_q;
	end

	// memory write-back
	always_ff @(posedge clk) begin
		if (upd_push) begin
			link_mem[sel_slot_q] <= top_eff;
			data_mem[sel_slot_q] <= value_q;
			top_mem[sid_q]       <= LINK_W'(sel_slot_q);
		end
		if (upd_pop) begin
			link_mem[sel_slot_q] <= free_head_q;
			top_mem[sid_q]       <= next_link;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// fresh slots are consumed in order, so a free head in the fresh region is its start
	`ASSERT_ALWAYS(a_fresh_order, clk, arst_n,
		(free_head_q < LINK_NULL && free_head_q >= fresh_q) |-> free_head_q == fresh_q)
	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fresh_q <= LINK_NULL)
	`ASSERT_ALWAYS(a_rsp_from_done, clk, arst_n,
		$rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
	`ASSERT_NEVER(a_no_write_on_error, clk, arst_n, (upd_push || upd_pop) && !sid_ok_q)

endmodule
`default_nettype wire
